// ----- hdl/adsr_pkg.sv -----
package adsr_pkg;

	localparam int TIME_W  = 16;
	localparam int AMP_FB  = 15;
	localparam int AMP_W   = AMP_FB + 1;
	localparam int OUT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int ACT_W   = 2;
	localparam int STAGE_W = 3;
	localparam int IDX_W   = 2;

	localparam int PROG_FB = 32;
	localparam int NEED_W  = TIME_W + 1;

	localparam int MX_W = PROG_FB + 1;
	localparam int MY_W = (TIME_W > OUT_W) ? ((TIME_W > AMP_W) ? TIME_W : AMP_W)
		: ((OUT_W > AMP_W) ? OUT_W : AMP_W);
	localparam int MP_W = MX_W + MY_W;
	localparam int MC_W = $clog2(MY_W);

	localparam int DQ_W = PROG_FB;
	localparam int DC_W = $clog2(DQ_W);

	localparam logic [AMP_W-1:0] AMP_ONE  = AMP_W'(1) << AMP_FB;
	localparam logic [MX_W-1:0]  PROG_ONE = MX_W'(1) << PROG_FB;

	localparam logic [CFG_W-1:0] ATTACK_RST  = CFG_W'(160);
	localparam logic [CFG_W-1:0] DECAY_RST   = CFG_W'(1600);
	localparam logic [CFG_W-1:0] SUSTAIN_RST = CFG_W'(16384);
	localparam logic [CFG_W-1:0] RELEASE_RST = CFG_W'(1600);

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} cfg_reg_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_ON   = 2'd1,
		ACT_OFF  = 2'd2
	} action_t;

	typedef enum logic [STAGE_W-1:0] {
		ST_ATTACK  = 3'd0,
		ST_DECAY   = 3'd1,
		ST_SUSTAIN = 3'd2,
		ST_RELEASE = 3'd3,
		ST_STOP    = 3'd4
	} stage_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RUN   = 8'b0000_0010,
		S_NEED  = 8'b0000_0100,
		S_CHECK = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_VAL   = 8'b0010_0000,
		S_AMP   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} fsm_t;

endpackage

// ----- hdl/adsr_if.sv -----
interface adsr_cmd_if import adsr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [TIME_W-1:0] elapsed_time;

	modport source (output valid, output action, output elapsed_time, input ready);
	modport sink (input valid, input action, input elapsed_time, output ready);
endinterface

interface adsr_res_if import adsr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   amplitude;
	logic [STAGE_W-1:0] stage_now;

	modport source (output valid, output amplitude, output stage_now, input ready);
	modport sink (input valid, input amplitude, input stage_now, output ready);
endinterface

// ----- hdl/adsr_mul.sv -----
module adsr_mul import adsr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MX_W-1:0] x,
	input  logic [MY_W-1:0] y,
	output logic            done,
	output logic [MP_W-1:0] prod
);

	logic [MP_W-1:0] acc_q;
	logic [MX_W-1:0] x_q;
	logic [MY_W-1:0] y_q;
	logic [MC_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [MX_W:0]   sum;

	assign sum  = {1'b0, acc_q[MP_W-1:MY_W]} + (y_q[0] ? {1'b0, x_q} : '0);
	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MC_W'(MY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MC_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MY_W-1:1]};
			y_q   <= y_q >> 1;
		end
	end

endmodule

// ----- hdl/adsr_div.sv -----
module adsr_div import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] num,
	input  logic [TIME_W-1:0] den,
	output logic              done,
	output logic [DQ_W-1:0]   quo
);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [DQ_W-1:0]   quo_q;
	logic [DC_W-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W:0]   rem2;
	logic [TIME_W:0]   diff;
	logic              ge;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DC_W'(DQ_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DC_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
			quo_q <= {quo_q[DQ_W-2:0], ge};
		end
	end

endmodule

// ----- hdl/adsr_envelope_generator.sv -----
// Channel  Role    Payload                          Transfer
// cmd      input   action, elapsed_time             cmd.valid & cmd.ready
// res      output  amplitude, stage_now             res.valid & res.ready
// cfg      write   cfg_index, cfg_data              cfg_wen
//
// One item at a time: a new cmd is taken only once the last result is loaded. The bit-serial
// multiplier and the restoring divider (one quotient bit a cycle) do the arithmetic of each item.
// arst_n clears the stage to stopped and the progress and release start to 0.
// A held result waits in the output register; cmd is taken again meanwhile.
module adsr_envelope_generator import adsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	adsr_cmd_if.sink         cmd,
	adsr_res_if.source       res,
	input  logic             cfg_wen,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	fsm_t               state_q;
	stage_t             stage_q;
	stage_t             next_stage;
	stage_t             stage_out_q;
	logic [PROG_FB-1:0] progress_q;
	logic [OUT_W-1:0]   rsa_q;
	logic [TIME_W-1:0]  e_q;
	logic [NEED_W-1:0]  need_q;
	logic [OUT_W-1:0]   val_q;
	logic [OUT_W-1:0]   amp_q;
	logic               res_valid_q;

	logic [CFG_W-1:0] attack_q;
	logic [CFG_W-1:0] decay_q;
	logic [CFG_W-1:0] sustain_q;
	logic [CFG_W-1:0] release_q;

	logic [TIME_W-1:0] t_cur;
	logic              timed;
	logic [AMP_W-1:0]  s_sat;
	logic [MX_W-1:0]   q_prog;
	logic              mul_start;
	logic [MX_W-1:0]   mul_x;
	logic [MY_W-1:0]   mul_y;
	logic              mul_done;
	logic [MP_W-1:0]   mul_prod;
	logic              div_start;
	logic              div_done;
	logic [DQ_W-1:0]   div_quo;
	logic [NEED_W-1:0] need_calc;
	logic              need_ge;
	logic [OUT_W-1:0]  val_direct;
	logic [OUT_W-1:0]  val_mul;
	logic              res_load;

	assign cmd.ready     = (state_q == S_IDLE);
	assign res.valid     = res_valid_q;
	assign res.amplitude = amp_q;
	assign res.stage_now = stage_out_q;
	assign res_load      = (state_q == S_FIN) && (!res_valid_q || res.ready);

	always_comb begin
		case (stage_q)
			ST_ATTACK:  t_cur = TIME_W'(attack_q);
			ST_DECAY:   t_cur = TIME_W'(decay_q);
			ST_RELEASE: t_cur = TIME_W'(release_q);
			default:    t_cur = '0;
		endcase
		timed = (stage_q == ST_ATTACK) || (stage_q == ST_DECAY) || (stage_q == ST_RELEASE);
		case (stage_q)
			ST_ATTACK:  next_stage = ST_DECAY;
			ST_DECAY:   next_stage = ST_SUSTAIN;
			ST_RELEASE: next_stage = ST_STOP;
			default:    next_stage = stage_q;
		endcase
		s_sat  = (32'(sustain_q) > 32'(AMP_ONE)) ? AMP_ONE : AMP_W'(sustain_q);
		q_prog = PROG_ONE - {1'b0, progress_q};

		need_calc = mul_prod[MP_W-1 -: NEED_W] + NEED_W'(|mul_prod[PROG_FB-1:0]);
		need_ge   = {1'b0, e_q} >= need_q;

		case (stage_q)
			ST_ATTACK:  val_direct = OUT_W'(progress_q >> (PROG_FB - AMP_FB));
			ST_SUSTAIN: val_direct = OUT_W'(s_sat);
			default:    val_direct = '0;
		endcase
		case (stage_q)
			ST_DECAY:   val_mul = OUT_W'(AMP_ONE - mul_prod[PROG_FB +: AMP_W]);
			ST_RELEASE: val_mul = OUT_W'(mul_prod[PROG_FB +: OUT_W]);
			default:    val_mul = '0;
		endcase

		mul_start = 1'b0;
		mul_x     = q_prog;
		mul_y     = MY_W'(t_cur);
		div_start = 1'b0;
		case (state_q)
			S_RUN: begin
				mul_start = timed && (t_cur != '0) && (progress_q != '0);
			end
			S_CHECK: begin
				div_start = !need_ge && (e_q != '0);
			end
			S_VAL: begin
				if (stage_q == ST_DECAY) begin
					mul_start = 1'b1;
					mul_x     = {1'b0, progress_q};
					mul_y     = MY_W'(AMP_ONE - s_sat);
				end else if (stage_q == ST_RELEASE) begin
					mul_start = 1'b1;
					mul_y     = MY_W'(rsa_q);
				end
			end
			default: begin
			end
		endcase
	end

	adsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (e_q),
		.den    (t_cur),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_data;
				REG_DECAY:   decay_q   <= cfg_data;
				REG_SUSTAIN: sustain_q <= cfg_data;
				REG_RELEASE: release_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stage_q     <= ST_STOP;
			progress_q  <= '0;
			rsa_q       <= '0;
			e_q         <= '0;
			need_q      <= '0;
			val_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						case (action_t'(cmd.action))
							ACT_TICK: e_q <= cmd.elapsed_time;
							ACT_ON: begin
								stage_q    <= ST_ATTACK;
								progress_q <= '0;
								e_q        <= '0;
							end
							ACT_OFF: begin
								if (stage_q == ST_ATTACK || stage_q == ST_DECAY
									|| stage_q == ST_SUSTAIN) begin
									stage_q    <= ST_RELEASE;
									progress_q <= '0;
								end
								e_q <= '0;
							end
							default: e_q <= '0;
						endcase
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (!timed) begin
						state_q <= S_VAL;
					end else if (t_cur == '0) begin
						stage_q    <= next_stage;
						progress_q <= '0;
					end else if (progress_q == '0) begin
						need_q  <= NEED_W'(t_cur);
						state_q <= S_CHECK;
					end else begin
						state_q <= S_NEED;
					end
				end
				S_NEED: begin
					if (mul_done) begin
						need_q  <= need_calc;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (need_ge) begin
						e_q        <= e_q - TIME_W'(need_q);
						stage_q    <= next_stage;
						progress_q <= '0;
						state_q    <= S_RUN;
					end else if (e_q == '0) begin
						state_q <= S_VAL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						progress_q <= progress_q + div_quo;
						state_q    <= S_VAL;
					end
				end
				S_VAL: begin
					if (stage_q == ST_DECAY || stage_q == ST_RELEASE) begin
						state_q <= S_AMP;
					end else begin
						val_q   <= val_direct;
						state_q <= S_FIN;
					end
				end
				S_AMP: begin
					if (mul_done) begin
						val_q   <= val_mul;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_load) begin
						if (stage_q != ST_RELEASE) begin
							rsa_q <= val_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			amp_q       <= val_q;
			stage_out_q <= stage_q;
		end
	end

endmodule

// ----- hdl/adsr_checker.sv -----
module adsr_checker import adsr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [OUT_W-1:0]   res_amplitude,
	input logic [STAGE_W-1:0] res_stage_now
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_amplitude)
			&& $stable(res_stage_now))
		else $error("result dropped or changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item taken while one is at work");

	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_amplitude) <= 32'(AMP_ONE))
		else $error("amplitude above full scale");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_stage_now == ST_STOP) |-> res_amplitude == '0)
		else $error("stopped envelope with nonzero amplitude");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_amplitude (res.amplitude),
	.res_stage_now (res.stage_now)
);
